FILE: rtl/core/jfps_pkg.sv
`default_nettype none

package jfps_pkg;

    localparam int GRID_MAX = 2048;
    localparam int GRID_MIN = 3;
    localparam int COL_W    = $clog2(GRID_MAX);
    localparam int CELL_W   = 32;
    localparam int CFG_W    = 12;
    localparam int SUM_W    = CELL_W + 2;
    localparam int M_TDATA_W = ((CELL_W + 2 * COL_W + 7) / 8) * 8;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic [COL_W-1:0] idx_t;

    // position of the incoming request and what the result for it looks like
    typedef struct packed {
        idx_t orow;
        idx_t col;
        logic last;
        logic interior;
    } pos_t;

    // line store write, issued when a request leaves the compute stage
    typedef struct packed {
        logic  en;
        idx_t  col;
        cell_t cur;
        cell_t up;
    } lb_wr_t;

    // floor of sum / 4 is an arithmetic shift; result always fits 32 bits
    function automatic cell_t quarter_floor(input logic signed [SUM_W-1:0] sum);
        return cell_t'(sum[SUM_W-1:2]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jfps_pos.sv
`default_nettype none

module jfps_pos
    import jfps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             accept,
    output pos_t                  pos
);

    idx_t row_reg, row_next;
    idx_t col_reg, col_next;
    idx_t last_idx_reg, last_idx_next;

    always_comb begin
        if (cfg_wdata < CFG_W'(GRID_MIN)) begin
            last_idx_next = COL_W'(GRID_MIN - 1);
        end else if (cfg_wdata > CFG_W'(GRID_MAX)) begin
            last_idx_next = COL_W'(GRID_MAX - 1);
        end else begin
            last_idx_next = COL_W'(cfg_wdata - CFG_W'(1));
        end
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we) begin
            row_next = '0;
            col_next = '0;
        end else if (accept) begin
            if (col_reg == last_idx_reg) begin
                col_next = '0;
                row_next = (row_reg == last_idx_reg) ? '0 : row_reg + COL_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            last_idx_reg <= COL_W'(GRID_MAX - 1);
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_we) begin
                last_idx_reg <= last_idx_next;
            end
        end
    end

    // row 0 emits the bottom border row of the new grid
    always_comb begin
        pos.orow     = (row_reg == '0) ? last_idx_reg : row_reg - COL_W'(1);
        pos.col      = col_reg;
        pos.last     = (row_reg == last_idx_reg) && (col_reg == last_idx_reg);
        pos.interior = (row_reg != '0) && (row_reg != COL_W'(1))
                       && (col_reg != '0) && (col_reg != last_idx_reg);
    end

endmodule

`default_nettype wire

FILE: rtl/core/jfps_lines.sv
`default_nettype none

module jfps_lines
    import jfps_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   rd_en,
    input  wire idx_t   rd_col,
    input  wire lb_wr_t wr,
    output cell_t       up_q,
    output cell_t       right_q,
    output cell_t       up_two_q
);

    cell_t above_mem [GRID_MAX];
    cell_t above_two_mem [GRID_MAX];

    idx_t rd_right;

    // reads past the last column and wraps only at GRID_MAX; that read only feeds a border result
    assign rd_right = rd_col + COL_W'(1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up_q     <= above_mem[rd_col];
            right_q  <= above_mem[rd_right];
            up_two_q <= above_two_mem[rd_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            above_mem[wr.col]     <= wr.cur;
            above_two_mem[wr.col] <= wr.up;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/jfps_calc.sv
`default_nettype none

module jfps_calc
    import jfps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  accept,
    input  wire cell_t in_cell,
    input  wire pos_t  in_pos,
    output logic       in_ready,
    input  wire cell_t up_q,
    input  wire cell_t right_q,
    input  wire cell_t up_two_q,
    output lb_wr_t     wr,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cell_t      out_value,
    output idx_t       out_row,
    output idx_t       out_col,
    output logic       out_last
);

    logic  st_valid_reg;
    cell_t st_cell_reg;
    pos_t  st_pos_reg;
    cell_t left_hold_reg;

    logic  out_valid_reg;
    cell_t out_value_reg;
    idx_t  out_row_reg;
    idx_t  out_col_reg;
    logic  out_last_reg;

    logic advance;
    logic signed [SUM_W-1:0] sum;
    cell_t value;

    assign advance  = st_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !st_valid_reg || advance;

    assign sum = SUM_W'(up_two_q) + SUM_W'(st_cell_reg)
               + SUM_W'(left_hold_reg) + SUM_W'(right_q);
    assign value = st_pos_reg.interior ? quarter_floor(sum) : '0;

    // shift the row stores down once the request leaves this stage
    always_comb begin
        wr.en  = advance;
        wr.col = st_pos_reg.col;
        wr.cur = st_cell_reg;
        wr.up  = up_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_hold_reg <= '0;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                left_hold_reg <= up_q;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_cell_reg <= in_cell;
            st_pos_reg  <= in_pos;
        end
        if (advance) begin
            out_value_reg <= value;
            out_row_reg   <= st_pos_reg.orow;
            out_col_reg   <= st_pos_reg.col;
            out_last_reg  <= st_pos_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/jacobi_four_point_stencil_unit.sv
// One Jacobi sweep over a square grid of signed Q16.16 cells streamed in raster
// order. Every input cell (i,j) yields one result: for i >= 1 the new value of
// cell (i-1,j), the floored quarter of its four neighbors, zero on the border;
// for row 0 the zero border cell (width-1,j). tlast marks the result of the
// final cell of the grid, after which the position wraps for the next sweep.
// One cell is taken every clock cycle unless m_axis_tready stalls the output;
// a cell passes through a compute stage that reads two line stores (the
// row above, read at two columns, and the row two above) and a result register.
// Write cfg_wdata (grid side, clamped to 3..2048) only while the block is idle;
// the write restarts the position at row 0, column 0. The line stores hold no
// reset state: the first two rows of a grid fill them before they are used.
`default_nettype none

module jacobi_four_point_stencil_unit
    import jfps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [CELL_W-1:0]    s_axis_tdata,  // cell_value
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // next_value, out_row, out_col, zero pad
    output logic                      m_axis_tlast   // grid_end
);

    logic   accept;
    pos_t   pos;
    lb_wr_t wr;
    cell_t  up_q;
    cell_t  right_q;
    cell_t  up_two_q;
    cell_t  out_value;
    idx_t   out_row;
    idx_t   out_col;

    assign accept = s_axis_tvalid && s_axis_tready;

    jfps_pos u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .pos       (pos)
    );

    jfps_lines u_lines (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_col   (pos.col),
        .wr       (wr),
        .up_q     (up_q),
        .right_q  (right_q),
        .up_two_q (up_two_q)
    );

    jfps_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_cell   (cell_t'(s_axis_tdata)),
        .in_pos    (pos),
        .in_ready  (s_axis_tready),
        .up_q      (up_q),
        .right_q   (right_q),
        .up_two_q  (up_two_q),
        .wr        (wr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({out_col, out_row, out_value});

endmodule

`default_nettype wire

FILE: rtl/core/jfps_checker.sv
`default_nettype none

module jfps_checker
    import jfps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                 m_axis_tlast
);

    logic [CELL_W-1:0] chk_value;
    idx_t              chk_row;
    idx_t              chk_col;

    assign chk_value = m_axis_tdata[CELL_W-1:0];
    assign chk_row   = m_axis_tdata[CELL_W+COL_W-1:CELL_W];
    assign chk_col   = m_axis_tdata[CELL_W+2*COL_W-1:CELL_W+COL_W];

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // the last cell of the grid emits cell (n-2, n-1)
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> chk_col == chk_row + COL_W'(1))
        else $error("grid end on wrong position");

    a_top_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && chk_row == '0 |-> chk_value == '0)
        else $error("top border result not zero");

    a_left_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && chk_col == '0 |-> chk_value == '0)
        else $error("left border result not zero");

endmodule

bind jacobi_four_point_stencil_unit jfps_checker u_jfps_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jfps_pkg::*;

    localparam int ITEMS     = 550;
    localparam int QUIET_AT  = 450;
    localparam int SETTLE    = 8;
    localparam int WATCHDOG  = 2000;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        cell_t next_value;
        idx_t  out_row;
        idx_t  out_col;
        logic  grid_end;
    } stencil_res_t;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] side;
        cell_t            din;
        stencil_res_t     res;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CELL_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    jacobi_four_point_stencil_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // stencil state mirrored from the block
    cell_t            line_up  [GRID_MAX];
    cell_t            line_up2 [GRID_MAX];
    cell_t            left_cell;
    int               row_pos;
    int               col_pos;
    logic [CFG_W-1:0] side_reg;

    stencil_res_t pending_results[$];

    // typed expectation travelling with the request currently driven
    bit           drv_known = 1'b0;
    stencil_res_t drv_exp   = '0;

    int src_rate    = 0;
    int dst_rate    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int fail_count  = 0;

    function automatic int grid_side(input logic [CFG_W-1:0] v);
        if (v < GRID_MIN) return GRID_MIN;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    function automatic stencil_res_t advance_stencil(input cell_t x);
        stencil_res_t res;
        int n, r, c;
        cell_t up, up2;
        logic signed [SUM_W-1:0] t_north, t_south, t_west, t_east, acc;
        n = grid_side(side_reg);
        r = (row_pos >= n) ? 0 : row_pos;
        c = (col_pos >= n) ? 0 : col_pos;
        up  = line_up[c];
        up2 = line_up2[c];
        res.next_value = '0;
        res.out_col    = idx_t'(c);
        res.grid_end   = (r == n - 1) && (c == n - 1);
        if (r == 0) begin
            res.out_row = idx_t'(n - 1);
        end else begin
            res.out_row = idx_t'(r - 1);
            if (r - 1 != 0 && c != 0 && c != n - 1) begin
                t_north = up2;
                t_south = x;
                t_west  = left_cell;
                t_east  = line_up[c + 1];
                acc = t_north + t_south + t_west + t_east;
                res.next_value = cell_t'(acc >>> 2);
            end
        end
        line_up2[c] = up;
        line_up[c]  = x;
        left_cell   = up;
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        row_pos = r;
        col_pos = c;
        return res;
    endfunction

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (dst_rate != 0 && $urandom_range(0, dst_rate) == 0) begin
            stall_left    <= $urandom_range(1, 19);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        stencil_res_t got, want, pred;
        bit moved;
        if (!aresetn) begin
            side_reg    = CFG_W'(GRID_MAX);
            row_pos     = 0;
            col_pos     = 0;
            left_cell   = '0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_we) begin
                side_reg = cfg_wdata;
                row_pos  = 0;
                col_pos  = 0;
                moved    = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved          = 1'b1;
                got.next_value = m_axis_tdata[CELL_W-1:0];
                got.out_row    = m_axis_tdata[CELL_W +: COL_W];
                got.out_col    = m_axis_tdata[CELL_W+COL_W +: COL_W];
                got.grid_end   = m_axis_tlast;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("unexpected result: value %h row %0d col %0d last %b",
                                 got.next_value, got.out_row, got.out_col, got.grid_end);
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_value !== want.next_value || got.out_row !== want.out_row ||
                        got.out_col !== want.out_col || got.grid_end !== want.grid_end) begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                                     want.next_value, want.out_row, want.out_col,
                                     want.grid_end, got.next_value, got.out_row,
                                     got.out_col, got.grid_end);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                pred  = advance_stencil(s_axis_tdata);
                pending_results.push_back(drv_known ? drv_exp : pred);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG) @(posedge aclk);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_cell(input cell_t v, input bit known, input stencil_res_t e);
        if (src_rate != 0 && $urandom_range(0, src_rate) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        drv_known     <= known;
        drv_exp       <= e;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] v);
        dir_row_t row;
        row.is_cfg = 1'b1;
        row.side   = v;
        row.din    = '0;
        row.res    = '0;
        return row;
    endfunction

    function automatic dir_row_t cell_row(input cell_t v, input int orow, input int col,
                                          input bit last, input cell_t nv);
        dir_row_t row;
        row.is_cfg         = 1'b0;
        row.side           = '0;
        row.din            = v;
        row.res.next_value = nv;
        row.res.out_row    = idx_t'(orow);
        row.res.out_col    = idx_t'(col);
        row.res.grid_end   = last;
        return row;
    endfunction

    function automatic cell_t rand_cell();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? cell_t'(32'h7FFF_FFFF) : cell_t'(32'h8000_0000);
            1: return cell_t'($urandom_range(0, 8)) - cell_t'(4);
            default: return cell_t'($urandom);
        endcase
    endfunction

    initial begin
        dir_row_t dir_tab[$];
        cell_t extremes[2];
        logic [CFG_W-1:0] side_val;
        int n, cells, rand_items, sel;

        // row 0 at reset width, then clamped widths, then full 3x3 grids of extremes
        dir_tab.push_back(cell_row(32'h7FFF_FFFF, GRID_MAX - 1, 0, 0, 0));
        dir_tab.push_back(cell_row(32'h8000_0000, GRID_MAX - 1, 1, 0, 0));
        dir_tab.push_back(cell_row(32'h0000_0000, GRID_MAX - 1, 2, 0, 0));
        dir_tab.push_back(cfg_row(12'hFFF));
        dir_tab.push_back(cell_row(32'hFFFF_FFFF, GRID_MAX - 1, 0, 0, 0));
        dir_tab.push_back(cfg_row(12'h000));
        extremes[0] = 32'h7FFF_FFFF;
        extremes[1] = 32'h8000_0000;
        foreach (extremes[k])
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    dir_tab.push_back(cell_row(extremes[k], (i == 0) ? 2 : i - 1, j,
                                               i == 2 && j == 2,
                                               (i == 2 && j == 1) ? extremes[k] : 0));
        // width 2 clamps to 3, left mid-grid on purpose
        dir_tab.push_back(cfg_row(12'd2));
        dir_tab.push_back(cell_row(32'h1234_5678, 2, 0, 0, 0));
        dir_tab.push_back(cell_row(32'hEDCB_A987, 2, 1, 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        src_rate = 4;
        dst_rate = 4;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg)
                write_width(dir_tab[k].side);
            else
                send_cell(dir_tab[k].din, 1'b1, dir_tab[k].res);
        end

        rand_items = 0;
        while (rand_items < ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                side_val = $urandom_range(0, 2);
            else if (sel == 1)
                side_val = $urandom_range(GRID_MAX, 4095);
            else if (sel < 4)
                side_val = $urandom_range(13, 20);
            else
                side_val = $urandom_range(3, 12);
            if (rand_items < QUIET_AT) begin
                src_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
                dst_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
            end else begin
                src_rate = 0;
                dst_rate = 0;
            end
            write_width(side_val);
            n = grid_side(side_val);
            if (n > 64) begin
                cells = $urandom_range(1, 40);
            end else begin
                cells = n * n * ((n <= 6) ? $urandom_range(1, 3) : 1);
                // broken grid: the next width write restarts mid-sweep
                if ($urandom_range(0, 4) == 0)
                    cells = $urandom_range(1, n * n - 1);
            end
            if (cells > ITEMS - rand_items)
                cells = ITEMS - rand_items;
            repeat (cells) begin
                send_cell(rand_cell(), 1'b0, '0);
                rand_items++;
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
